// ----- design/wmab_pkg.sv -----
// ----------------------------------------------------------------------------
// wmab_pkg: shared types and constants of the weighted moving average bank
// Sizes of the sample ring, the running sums and the serial divider, plus the
// request opcodes.
// ----------------------------------------------------------------------------
package wmab_pkg;

   // ring size and sample width
   localparam int DEPTH        = 256;
   localparam int SAMPLE_BITS  = 24;

   // fixed widths of the channel fields
   localparam int SAMPLE_FIELD_BITS = 24;
   localparam int WINDOW_BITS       = 9;
   localparam int AVERAGE_BITS      = 24;

   // derived widths
   localparam int ADDR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(DEPTH + 1);
   localparam int PSUM_BITS    = SAMPLE_BITS + CNT_BITS;   // sum of up to DEPTH samples
   localparam int SUM_BITS     = PSUM_BITS + CNT_BITS;     // weighted sum
   localparam int DEN_BITS     = 2 * CNT_BITS;             // w(w+1)/2
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;
   typedef logic [SAMPLE_BITS-1:0]        sample_type;
   typedef logic [PSUM_BITS-1:0]          psum_type;
   typedef logic [SUM_BITS-1:0]           sum_type;
   typedef logic [DEN_BITS-1:0]           den_type;
   typedef logic [DIV_CNT_BITS-1:0]       div_cnt_type;
   typedef logic [SAMPLE_FIELD_BITS-1:0]  sample_field_type;
   typedef logic [WINDOW_BITS-1:0]        window_field_type;
   typedef logic [AVERAGE_BITS-1:0]       average_field_type;

   // request opcodes
   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

endpackage

// ----- design/wmab_req_if.sv -----
// ----------------------------------------------------------------------------
// wmab_req_if: request channel of the weighted moving average bank
// Valid/ready channel carrying one push or query beat.
// ----------------------------------------------------------------------------
interface wmab_req_if;

   logic                               valid;
   logic                               ready;
   wmab_pkg::opcode_type               opcode;
   wmab_pkg::sample_field_type         sample;
   wmab_pkg::window_field_type         window;

   modport source (output valid, output opcode, output sample, output window,
                   input ready);
   modport sink   (input valid, input opcode, input sample, input window,
                   output ready);

endinterface

// ----- design/wmab_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wmab_rsp_if: response channel of the weighted moving average bank
// Valid/ready channel carrying one average beat per query.
// ----------------------------------------------------------------------------
interface wmab_rsp_if;

   logic                               valid;
   logic                               ready;
   wmab_pkg::average_field_type        average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);

endinterface

// ----- design/weighted_moving_average_bank.sv -----
// ----------------------------------------------------------------------------
// weighted_moving_average_bank: linearly weighted moving average over a ring
// Push beats store samples in a 256-entry ring; query beats return the
// weighted average of the newest w samples (newest weight w, oldest 1).
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    opcode[0], sample[23:0], window[8:0]
//   rsp_bus   out   valid/ready    average[23:0]
//
// A push stores its sample in the ring. A query of window w (clamped to at most 256;
// a window of 0 returns zero) walks the ring (one sample read a cycle from the
// single ring read port), runs bit-serial restoring division of the 42-bit
// weighted sum, and then loads the response register.
// Reset clears the write pointer and fill count; unwritten slots read as zero.
// Requests are taken only while no query is in flight; a stalled response
// holds in its register and the next beat may still be accepted.
// ----------------------------------------------------------------------------
module weighted_moving_average_bank (
   input  logic       clock,
   input  logic       reset,
   wmab_req_if.sink   req_bus,
   wmab_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TAIL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                     state_ff;
   wmab_pkg::addr_type            wr_slot_ff;
   wmab_pkg::cnt_type             fill_ff;
   wmab_pkg::cnt_type             w_ff;
   wmab_pkg::cnt_type             k_ff;
   wmab_pkg::addr_type            rd_addr_ff;
   logic                          rd_vld_ff;
   logic                          rd_live_ff;
   wmab_pkg::sample_type          rd_data_ff;
   wmab_pkg::psum_type            psum_ff;
   wmab_pkg::sum_type             acc_ff;
   wmab_pkg::den_type             den_ff;
   wmab_pkg::den_type             rem_ff;
   wmab_pkg::sum_type             quo_ff;
   wmab_pkg::div_cnt_type         div_cnt_ff;
   logic                          rsp_valid_ff;
   wmab_pkg::average_field_type   rsp_average_ff;

   wmab_pkg::sample_type          hist_mem [wmab_pkg::DEPTH];

   logic                          req_accept;
   logic                          push_accept;
   logic                          query_accept;
   wmab_pkg::cnt_type             w_in;
   wmab_pkg::sample_type          sample_val;
   wmab_pkg::psum_type            psum_in;
   wmab_pkg::sum_type             acc_in;
   logic [wmab_pkg::DEN_BITS:0]   trial;
   logic                          fits;
   wmab_pkg::den_type             rem_in;
   wmab_pkg::sum_type             quo_in;

   // handshake
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign req_accept     = req_bus.valid && (state_ff == ST_IDLE);
   assign push_accept    = req_accept && (req_bus.opcode == wmab_pkg::OP_PUSH);
   assign query_accept   = req_accept && (req_bus.opcode == wmab_pkg::OP_QUERY);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.average = rsp_average_ff;

   // window clamp: larger than the ring means the whole ring
   always_comb begin
      if (int'(req_bus.window) > wmab_pkg::DEPTH) begin
         w_in = wmab_pkg::cnt_type'(wmab_pkg::DEPTH);
      end else begin
         w_in = wmab_pkg::cnt_type'(req_bus.window);
      end
   end

   // running sums: weighted sum is the sum of prefix sums from the newest
   assign sample_val = rd_live_ff ? rd_data_ff : '0;
   assign psum_in    = psum_ff + wmab_pkg::psum_type'(sample_val);
   assign acc_in     = acc_ff + wmab_pkg::sum_type'(psum_in);

   // one restoring division step
   assign trial  = {rem_ff, quo_ff[wmab_pkg::SUM_BITS-1]};
   assign fits   = (trial >= {1'b0, den_ff});
   assign rem_in = fits ? wmab_pkg::den_type'(trial - {1'b0, den_ff})
                        : trial[wmab_pkg::DEN_BITS-1:0];
   assign quo_in = {quo_ff[wmab_pkg::SUM_BITS-2:0], fits};

   // sample ring, registered read
   always_ff @(posedge clock) begin
      if (push_accept) begin
         hist_mem[wr_slot_ff] <= wmab_pkg::sample_type'(req_bus.sample);
      end
      rd_data_ff <= hist_mem[rd_addr_ff];
   end

   // sequencer, datapath and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_slot_ff   <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= 1'b0;

         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // fold in the sample read last cycle
         if (rd_vld_ff) begin
            psum_ff <= psum_in;
            acc_ff  <= acc_in;
         end

         case (state_ff)
            ST_IDLE: begin
               if (push_accept) begin
                  wr_slot_ff <= (wr_slot_ff == wmab_pkg::addr_type'(wmab_pkg::DEPTH - 1))
                              ? '0 : wr_slot_ff + wmab_pkg::addr_type'(1);
                  if (fill_ff != wmab_pkg::cnt_type'(wmab_pkg::DEPTH)) begin
                     fill_ff <= fill_ff + wmab_pkg::cnt_type'(1);
                  end
               end
               if (query_accept) begin
                  if (w_in == '0) begin
                     quo_ff   <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     w_ff       <= w_in;
                     k_ff       <= '0;
                     rd_addr_ff <= (wr_slot_ff == '0)
                                 ? wmab_pkg::addr_type'(wmab_pkg::DEPTH - 1)
                                 : wr_slot_ff - wmab_pkg::addr_type'(1);
                     den_ff     <= '0;
                     psum_ff    <= '0;
                     acc_ff     <= '0;
                     state_ff   <= ST_WALK;
                  end
               end
            end

            // issue one ring read a cycle, newest first
            ST_WALK: begin
               rd_vld_ff  <= 1'b1;
               rd_live_ff <= (k_ff < fill_ff);
               rd_addr_ff <= (rd_addr_ff == '0)
                           ? wmab_pkg::addr_type'(wmab_pkg::DEPTH - 1)
                           : rd_addr_ff - wmab_pkg::addr_type'(1);
               den_ff     <= den_ff + wmab_pkg::den_type'(k_ff)
                           + wmab_pkg::den_type'(1);
               k_ff       <= k_ff + wmab_pkg::cnt_type'(1);
               if (k_ff == w_ff - wmab_pkg::cnt_type'(1)) begin
                  state_ff <= ST_TAIL;
               end
            end

            // last sample lands; load the dividend
            ST_TAIL: begin
               quo_ff     <= acc_in;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end

            // one quotient bit a cycle
            ST_DIV: begin
               rem_ff     <= rem_in;
               quo_ff     <= quo_in;
               div_cnt_ff <= div_cnt_ff + wmab_pkg::div_cnt_type'(1);
               if (div_cnt_ff == wmab_pkg::div_cnt_type'(wmab_pkg::SUM_BITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end

            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_average_ff <= wmab_pkg::average_field_type'(quo_ff);
                  state_ff       <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a push never produces a response beat
   assert property (@(posedge clock) disable iff (reset)
      push_accept |=> !$rose(rsp_valid_ff))
      else $error("response raised after a push");

   // divider remainder stays below the denominator
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("remainder not below denominator");

   // the walk never issues past the window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (k_ff < w_ff))
      else $error("ring walk overran the window");

   // fill count never exceeds the ring size
   assert property (@(posedge clock) disable iff (reset)
      push_accept |=> (fill_ff <= wmab_pkg::cnt_type'(wmab_pkg::DEPTH)) && (fill_ff != '0))
      else $error("fill count out of range");

endmodule
